### design/tcw_pkg.sv
// tcw_pkg: shared types and constants for the text console writer
// holds function codes, control characters, cell word layout and memory control
// no dependencies
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int POS_W = 11;

  typedef enum logic [1:0] {
    FN_PUT   = 2'd0,
    FN_SET   = 2'd1,
    FN_CLEAR = 2'd2,
    FN_READ  = 2'd3
  } func_t;

  localparam logic [1:0] DK_NONE  = 2'd0;
  localparam logic [1:0] DK_COLOR = 2'd2;

  localparam logic [7:0] KEY_BS  = 8'd8;
  localparam logic [7:0] KEY_TAB = 8'd9;
  localparam logic [7:0] KEY_NL  = 8'd10;
  localparam logic [7:0] KEY_CR  = 8'd13;

  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] chr;
  } cell_t;

  localparam cell_t CLEAR_CELL  = '{attr: 8'h0F, chr: 8'h00};
  localparam cell_t SCROLL_CELL = '{attr: 8'h07, chr: 8'h00};

  typedef struct packed {
    logic wr_char;
    logic wr_attr;
    logic rd;
  } mem_ctl_t;

endpackage

### design/tcw_cell_store.sv
// tcw_cell_store: character and attribute cell memory
// one write port with byte enables, one registered read port; uses tcw_pkg
`timescale 1ns / 1ps

module tcw_cell_store
  import tcw_pkg::*;
#(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic          clk,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] wr_addr,
  input  cell_t         wr_cell,
  input  logic [AW-1:0] rd_addr,
  output cell_t         rd_cell
);

  logic [7:0] chr_mem  [DEPTH];
  logic [7:0] attr_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_char) begin
      chr_mem[wr_addr] <= wr_cell.chr;
    end
    if (ctl.wr_attr) begin
      attr_mem[wr_addr] <= wr_cell.attr;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_cell.chr  <= chr_mem[rd_addr];
      rd_cell.attr <= attr_mem[rd_addr];
    end
  end

endmodule

### design/tcw_seq.sv
// tcw_seq: cursor registers and sequencer for the text console writer
// one address counter drives clear, scroll copy and fill sweeps; uses tcw_pkg
`timescale 1ns / 1ps

module tcw_seq
  import tcw_pkg::*;
#(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8,
  parameter int CELLS    = COLUMNS * ROWS,
  parameter int AW       = $clog2(CELLS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  func_t            func,
  input  logic [7:0]       char_code,
  input  logic [7:0]       color,
  input  logic [6:0]       col,
  input  logic [4:0]       row,
  input  logic [1:0]       display_kind,
  output logic             busy,
  output logic             done,
  output logic [POS_W-1:0] cursor_pos,
  output logic [7:0]       cell_char,
  output logic [7:0]       cell_attr,
  output mem_ctl_t         mem_ctl,
  output logic [AW-1:0]    wr_addr,
  output cell_t            wr_cell,
  output logic [AW-1:0]    rd_addr,
  input  cell_t            rd_cell
);

  localparam int CW     = $clog2(COLUMNS);
  localparam int RW     = $clog2(ROWS);
  localparam int TW     = $clog2(COLUMNS + TAB_STOP);
  localparam int NTAB   = (COLUMNS - 1) / TAB_STOP;
  localparam int MOVE_N = CELLS - COLUMNS;

  localparam logic [CW:0]   COL_END  = (CW + 1)'(COLUMNS);
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
  localparam logic [RW:0]   ROW_END  = (RW + 1)'(ROWS);
  localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
  localparam logic [AW-1:0] IDX_LAST = AW'(CELLS - 1);
  localparam logic [AW-1:0] IDX_MOVE = AW'(MOVE_N);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_READ   = 4'b0010,
    ST_SCROLL = 4'b0100,
    ST_FILL   = 4'b1000
  } state_t;

  state_t        state, state_next;
  logic [AW-1:0] cnt, cnt_next;
  logic          fill_scroll, fill_scroll_next;
  logic          report, report_next;
  logic [CW-1:0] cur_col, cur_col_next;
  logic [RW-1:0] cur_line, cur_line_next;
  logic          done_next;
  logic [7:0]    cell_char_next, cell_attr_next;

  logic [AW-1:0] cur_idx;
  logic [CW-1:0] col_c;
  logic [RW-1:0] row_c;
  logic [AW-1:0] rd_idx;

  logic [NTAB:0] tab_ge;
  logic [TW-1:0] tab_next;

  logic [CW:0]   put_col;
  logic [RW:0]   put_line;
  logic          put_wr_char, put_wr_attr;
  logic [AW-1:0] put_addr;
  cell_t         put_cell;
  logic          put_scroll;

  assign cur_idx    = AW'(int'(cur_line) * COLUMNS + int'(cur_col));
  assign cursor_pos = POS_W'(cur_idx);
  assign busy       = (state != ST_IDLE);

  assign col_c  = (col > 7'(COLUMNS - 1)) ? COL_LAST : CW'(col);
  assign row_c  = (row > 5'(ROWS - 1)) ? ROW_LAST : RW'(row);
  assign rd_idx = AW'(int'(row_c) * COLUMNS + int'(col_c));

  // next tab stop: one plus the count of nonzero stops at or left of the cursor, times TAB_STOP
  always_comb begin
    tab_ge[0] = 1'b0;
    for (int k = 1; k <= NTAB; k++) begin
      tab_ge[k] = (TW'(cur_col) >= TW'(k * TAB_STOP));
    end
    tab_next = TW'(($countones(tab_ge) + 1) * TAB_STOP);
  end

  always_comb begin
    put_col     = {1'b0, cur_col};
    put_line    = {1'b0, cur_line};
    put_wr_char = 1'b0;
    put_wr_attr = 1'b0;
    put_addr    = cur_idx;
    put_cell    = '{attr: color, chr: char_code};
    case (char_code)
      KEY_NL: begin
        put_col  = '0;
        put_line = {1'b0, cur_line} + 1'b1;
      end
      KEY_TAB: begin
        if (tab_next > TW'(COLUMNS - 1)) begin
          put_col  = '0;
          put_line = {1'b0, cur_line} + 1'b1;
        end else begin
          put_col = (CW + 1)'(tab_next);
        end
      end
      KEY_CR: begin
        put_col = '0;
      end
      KEY_BS: begin
        if (cur_col != '0) begin
          put_col       = {1'b0, cur_col} - 1'b1;
          put_wr_char   = 1'b1;
          put_addr      = cur_idx - 1'b1;
          put_cell.chr  = 8'h00;
        end else if (cur_line != '0) begin
          put_line = {1'b0, cur_line} - 1'b1;
          put_col  = {1'b0, COL_LAST};
        end
      end
      default: begin
        put_wr_char = 1'b1;
        put_wr_attr = (display_kind == DK_COLOR);
        put_col     = {1'b0, cur_col} + 1'b1;
      end
    endcase
    if (put_col == COL_END) begin
      put_col  = '0;
      put_line = put_line + 1'b1;
    end
    put_scroll = (put_line == ROW_END);
  end

  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    fill_scroll_next = fill_scroll;
    report_next      = report;
    cur_col_next     = cur_col;
    cur_line_next    = cur_line;
    done_next        = 1'b0;
    cell_char_next   = cell_char;
    cell_attr_next   = cell_attr;
    mem_ctl          = '0;
    wr_addr          = cur_idx;
    wr_cell          = put_cell;
    rd_addr          = rd_idx;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cell_char_next = 8'h00;
          cell_attr_next = 8'h00;
          if (display_kind == DK_NONE) begin
            done_next = 1'b1;
          end else begin
            case (func)
              FN_PUT: begin
                mem_ctl.wr_char = put_wr_char;
                mem_ctl.wr_attr = put_wr_attr;
                wr_addr         = put_addr;
                cur_col_next    = CW'(put_col);
                if (put_scroll) begin
                  cur_line_next = ROW_LAST;
                  cnt_next      = '0;
                  state_next    = ST_SCROLL;
                end else begin
                  cur_line_next = RW'(put_line);
                  done_next     = 1'b1;
                end
              end
              FN_SET: begin
                cur_col_next  = col_c;
                cur_line_next = row_c;
                done_next     = 1'b1;
              end
              FN_CLEAR: begin
                cur_col_next     = '0;
                cur_line_next    = '0;
                cnt_next         = '0;
                fill_scroll_next = 1'b0;
                report_next      = 1'b1;
                state_next       = ST_FILL;
              end
              FN_READ: begin
                mem_ctl.rd = 1'b1;
                state_next = ST_READ;
              end
              default: begin
                done_next = 1'b1;
              end
            endcase
          end
        end
      end
      ST_READ: begin
        cell_char_next = rd_cell.chr;
        cell_attr_next = rd_cell.attr;
        done_next      = 1'b1;
        state_next     = ST_IDLE;
      end
      ST_SCROLL: begin
        // read one line below, write the word read last cycle
        rd_addr    = AW'(int'(cnt) + COLUMNS);
        mem_ctl.rd = (cnt != IDX_MOVE);
        wr_addr    = cnt - 1'b1;
        wr_cell    = rd_cell;
        if (cnt != '0) begin
          mem_ctl.wr_char = 1'b1;
          mem_ctl.wr_attr = 1'b1;
        end
        if (cnt == IDX_MOVE) begin
          fill_scroll_next = 1'b1;
          report_next      = 1'b1;
          state_next       = ST_FILL;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_FILL: begin
        mem_ctl.wr_char = 1'b1;
        mem_ctl.wr_attr = 1'b1;
        wr_addr         = cnt;
        wr_cell         = fill_scroll ? SCROLL_CELL : CLEAR_CELL;
        if (cnt == IDX_LAST) begin
          done_next  = report;
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_FILL;
      cnt         <= '0;
      fill_scroll <= 1'b0;
      report      <= 1'b0;
      cur_col     <= '0;
      cur_line    <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      cnt         <= cnt_next;
      fill_scroll <= fill_scroll_next;
      report      <= report_next;
      cur_col     <= cur_col_next;
      cur_line    <= cur_line_next;
      done        <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cell_char <= cell_char_next;
    cell_attr <= cell_attr_next;
  end

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while sequencer busy");
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (int'(cur_col) < COLUMNS) && (int'(cur_line) < ROWS))
    else $error("cursor outside the screen");
  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    (mem_ctl.wr_char || mem_ctl.wr_attr) |-> (int'(wr_addr) < CELLS))
    else $error("cell write outside the store");
  a_off_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && display_kind == DK_NONE) |=> done)
    else $error("item with no display did not finish at once");
  a_set_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && display_kind != DK_NONE && func == FN_SET) |=> done)
    else $error("set cursor did not finish at once");
`endif

endmodule

### design/text_console_char_writer_core.sv
// text_console_char_writer_core: text console engine with cursor and cell store
// holds the display kind register; instantiates tcw_seq and tcw_cell_store; uses tcw_pkg
//
//   channel  handshake           word
//   input    start / busy        func, char_code, color, col, row
//   config   cfg_valid/cfg_ready cfg_data (display kind)
//   result   done (one cycle)    cursor_pos, cell_char, cell_attr
//
// set cursor, put character without scroll, and any item with no display: done in the next cycle
// read cell: done follows the registered memory read port, then the ST_READ state
// scroll: runs through the shared address counter (copy, then fill of last line)
// clear and home: one fill sweep over all COLUMNS*ROWS cells; the same sweep runs after reset with busy high
// done is a pulse that the receiver cannot hold off; cfg_ready is always high
`timescale 1ns / 1ps

module text_console_char_writer_core
  import tcw_pkg::*;
#(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       func,
  input  logic [7:0]       char_code,
  input  logic [7:0]       color,
  input  logic [6:0]       col,
  input  logic [4:0]       row,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_data,
  output logic             done,
  output logic [POS_W-1:0] cursor_pos,
  output logic [7:0]       cell_char,
  output logic [7:0]       cell_attr
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  logic [1:0]    display_kind;
  mem_ctl_t      mem_ctl;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  cell_t         wr_cell;
  cell_t         rd_cell;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_kind <= DK_COLOR;
    end else if (cfg_valid && cfg_ready) begin
      display_kind <= cfg_data;
    end
  end

  tcw_seq #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP),
    .CELLS    (CELLS),
    .AW       (AW)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .func         (func_t'(func)),
    .char_code    (char_code),
    .color        (color),
    .col          (col),
    .row          (row),
    .display_kind (display_kind),
    .busy         (busy),
    .done         (done),
    .cursor_pos   (cursor_pos),
    .cell_char    (cell_char),
    .cell_attr    (cell_attr),
    .mem_ctl      (mem_ctl),
    .wr_addr      (wr_addr),
    .wr_cell      (wr_cell),
    .rd_addr      (rd_addr),
    .rd_cell      (rd_cell)
  );

  tcw_cell_store #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (wr_addr),
    .wr_cell (wr_cell),
    .rd_addr (rd_addr),
    .rd_cell (rd_cell)
  );

endmodule

### tb/text_console_char_writer_core_tb.sv
// text_console_char_writer_core_tb: self-checking bench for the text console engine
// drives put/set/clear/read items and display kind writes; predicts every result word
// depends on tcw_pkg and text_console_char_writer_core
`timescale 1ns / 1ps

module text_console_char_writer_core_tb;
  import tcw_pkg::*;

  localparam int COLUMNS        = 80;
  localparam int ROWS           = 25;
  localparam int TAB_STOP       = 8;
  localparam int CELLS          = COLUMNS * ROWS;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int TAIL_CYCLES    = 8;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [7:0]       chr;
    logic [7:0]       attr;
  } screen_word_t;

  class console_scoreboard;
    logic [1:0]   kind;
    int           cur_col;
    int           cur_line;
    cell_t        cells[CELLS];
    screen_word_t expected_words[$];
    int           errors;

    function new();
      kind = DK_COLOR;
      cur_col = 0;
      cur_line = 0;
      errors = 0;
      wipe();
    endfunction

    function void wipe();
      for (int i = 0; i < CELLS; i++) cells[i] = CLEAR_CELL;
    endfunction

    function void apply_kind(logic [1:0] v);
      kind = v;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void scroll_up();
      for (int i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) cells[i] = SCROLL_CELL;
      cur_line = ROWS - 1;
    endfunction

    function void put_char(logic [7:0] ch, logic [7:0] attr);
      int nxt;
      int k;
      if (ch == KEY_NL) begin
        cur_col = 0;
        cur_line++;
      end else if (ch == KEY_TAB) begin
        nxt = cur_col + TAB_STOP - (cur_col % TAB_STOP);
        if (nxt > COLUMNS - 1) begin
          cur_line++;
          cur_col = 0;
        end else begin
          cur_col = nxt;
        end
      end else if (ch == KEY_CR) begin
        cur_col = 0;
      end else if (ch == KEY_BS) begin
        if (cur_col > 0) begin
          cur_col--;
          cells[cur_line * COLUMNS + cur_col].chr = 8'h00;
        end else if (cur_line > 0) begin
          cur_line--;
          cur_col = COLUMNS - 1;
        end
      end else begin
        k = cur_line * COLUMNS + cur_col;
        cells[k].chr = ch;
        if (kind == DK_COLOR) cells[k].attr = attr;
        cur_col++;
      end
      if (cur_col >= COLUMNS) begin
        cur_col = 0;
        cur_line++;
      end
      if (cur_line >= ROWS) scroll_up();
    endfunction

    function void note_item(func_t fn, logic [7:0] ch, logic [7:0] attr,
                            logic [6:0] c, logic [4:0] r);
      screen_word_t w;
      int sc;
      int sr;
      sc = (c > COLUMNS - 1) ? COLUMNS - 1 : int'(c);
      sr = (r > ROWS - 1) ? ROWS - 1 : int'(r);
      w.chr = 8'h00;
      w.attr = 8'h00;
      if (kind != DK_NONE) begin
        case (fn)
          FN_PUT: put_char(ch, attr);
          FN_SET: begin
            cur_col = sc;
            cur_line = sr;
          end
          FN_CLEAR: begin
            wipe();
            cur_col = 0;
            cur_line = 0;
          end
          default: begin
            w.chr = cells[sr * COLUMNS + sc].chr;
            w.attr = cells[sr * COLUMNS + sc].attr;
          end
        endcase
      end
      w.pos = POS_W'(cur_line * COLUMNS + cur_col);
      expected_words.push_back(w);
    endfunction

    function void check_word(logic [POS_W-1:0] pos, logic [7:0] chr, logic [7:0] attr);
      screen_word_t w;
      if (expected_words.size() == 0) begin
        $error("result word with none expected: cursor_pos %0d", pos);
        errors++;
        return;
      end
      w = expected_words.pop_front();
      if (pos !== w.pos) begin
        $error("cursor_pos expected %0d actual %0d", w.pos, pos);
        errors++;
      end
      if (chr !== w.chr) begin
        $error("cell_char expected 0x%02h actual 0x%02h", w.chr, chr);
        errors++;
      end
      if (attr !== w.attr) begin
        $error("cell_attr expected 0x%02h actual 0x%02h", w.attr, attr);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       func = FN_PUT;
  logic [7:0]       char_code = 8'h00;
  logic [7:0]       color = 8'h00;
  logic [6:0]       col = 7'd0;
  logic [4:0]       row = 5'd0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_data = 2'd0;
  logic             done;
  logic [POS_W-1:0] cursor_pos;
  logic [7:0]       cell_char;
  logic [7:0]       cell_attr;

  int idle_cycles = 0;
  console_scoreboard sb = new();

  text_console_char_writer_core #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .char_code  (char_code),
    .color      (color),
    .col        (col),
    .row        (row),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .done       (done),
    .cursor_pos (cursor_pos),
    .cell_char  (cell_char),
    .cell_attr  (cell_attr)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) sb.check_word(cursor_pos, cell_char, cell_attr);
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic issue(func_t fn, logic [7:0] ch, logic [7:0] attr,
                       logic [6:0] c, logic [4:0] r);
    start <= 1'b1;
    func <= fn;
    char_code <= ch;
    color <= attr;
    col <= c;
    row <= r;
    do @(posedge clk); while (busy);
    sb.note_item(fn, ch, attr, c, r);
  endtask

  task automatic hold_off(int n);
    if (n == 0) return;
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // wait until every expected word has come back and the block is idle
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0 || busy);
  endtask

  task automatic write_kind(logic [1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.apply_kind(v);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item();
    int         pick;
    func_t      fn;
    logic [7:0] ch;
    logic [6:0] c;
    logic [4:0] r;
    pick = $urandom_range(0, 99);
    if (pick < 70) fn = FN_PUT;
    else if (pick < 82) fn = FN_SET;
    else if (pick < 98) fn = FN_READ;
    else fn = FN_CLEAR;
    ch = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0: ch = KEY_NL;
        1: ch = KEY_TAB;
        2: ch = KEY_CR;
        default: ch = KEY_BS;
      endcase
    end
    if ($urandom_range(0, 7) == 0) c = 7'($urandom_range(0, 127));
    else c = 7'($urandom_range(0, COLUMNS - 1));
    if ($urandom_range(0, 7) == 0) r = 5'($urandom_range(0, 31));
    else r = 5'($urandom_range(0, ROWS - 1));
    issue(fn, ch, 8'($urandom_range(0, 255)), c, r);
  endtask

  task automatic random_bursts(int n_items, bit gapless);
    int sent;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < n_items; k++) begin
        random_item();
        sent++;
      end
      if (!gapless) hold_off($urandom_range(0, 6));
    end
  endtask

  logic [1:0] phase_kind[5] = '{2'd2, 2'd1, 2'd0, 2'd3, 2'd2};
  int         phase_items[5] = '{100, 80, 40, 60, 100};

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    issue(FN_READ, 8'h00, 8'h00, 7'd0, 5'd0);
    issue(FN_PUT, 8'h41, 8'hFF, 7'd0, 5'd0);
    issue(FN_PUT, 8'hFF, 8'h00, 7'd127, 5'd31);
    issue(FN_PUT, 8'h00, 8'h5A, 7'd0, 5'd0);
    issue(FN_PUT, KEY_TAB, 8'h00, 7'd0, 5'd0);
    issue(FN_PUT, KEY_BS, 8'h00, 7'd0, 5'd0);
    issue(FN_READ, 8'h00, 8'h00, 7'd7, 5'd0);
    issue(FN_PUT, KEY_CR, 8'h00, 7'd0, 5'd0);
    issue(FN_PUT, KEY_BS, 8'h00, 7'd0, 5'd0);
    issue(FN_PUT, KEY_NL, 8'h00, 7'd0, 5'd0);
    issue(FN_PUT, KEY_BS, 8'h00, 7'd0, 5'd0);
    issue(FN_PUT, 8'h5A, 8'h1E, 7'd0, 5'd0);
    issue(FN_SET, 8'h00, 8'h00, 7'd76, 5'd3);
    issue(FN_PUT, KEY_TAB, 8'h00, 7'd0, 5'd0);
    issue(FN_SET, 8'h00, 8'h00, 7'd127, 5'd31);
    issue(FN_PUT, 8'h78, 8'hC3, 7'd0, 5'd0);
    issue(FN_READ, 8'h00, 8'h00, 7'd79, 5'd23);
    issue(FN_READ, 8'h00, 8'h00, 7'd127, 5'd31);
    issue(FN_PUT, KEY_NL, 8'h00, 7'd0, 5'd0);
    issue(FN_READ, 8'h00, 8'h00, 7'd79, 5'd22);
    issue(FN_CLEAR, 8'h00, 8'h00, 7'd0, 5'd0);
    issue(FN_READ, 8'h00, 8'h00, 7'd79, 5'd24);

    for (int p = 0; p < 5; p++) begin
      settle();
      write_kind(phase_kind[p]);
      random_bursts(phase_items[p] / 2, p == 3);
      settle();
      random_bursts(phase_items[p] - phase_items[p] / 2, p == 3);
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
